/* src/atfr_pkg.sv */
// ----------------------------------------------------------------------------
// atfr_pkg
// Shared constants and helpers for the associative tag table with FIFO
// replacement: field widths, command codes and default sizes.
// ----------------------------------------------------------------------------
package atfr_pkg;

    // Fixed widths of the word fields at the ports
    localparam int KEY_W  = 64;
    localparam int LEN_W  = 20;
    localparam int SLOT_W = 4;

    // Default sizes handed to the top level parameters
    localparam int ENTRIES_DEF  = 16;
    localparam int KEY_BITS_DEF = 64;
    localparam int LEN_BITS_DEF = 20;

    // Slot age: four bits, saturating
    localparam int          AGE_BITS = 4;
    localparam logic [3:0]  AGE_MAX  = 4'd15;

    // Command codes
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    // Advance an age by one, stopping at the ceiling
    function automatic logic [AGE_BITS-1:0] age_step(input logic [AGE_BITS-1:0] age);
        logic [AGE_BITS-1:0] res;
        res = (age == AGE_MAX) ? age : age + 1'b1;
        return res;
    endfunction

endpackage

/* src/assoc_tag_table_fifo_replace.sv */
// ----------------------------------------------------------------------------
// assoc_tag_table_fifo_replace
// Fully associative tag table with FIFO replacement, held in two RAMs.
// ----------------------------------------------------------------------------
// One word is handled at a time. Keys and lengths sit in one RAM, slot ages
// in a second, valid marks in flip-flops cleared by reset. Every command scans
// the slots one per cycle through the registered RAM read port. A lookup
// stops at the first valid match; an insert always makes the full scan, which
// also writes back each aged entry, then a commit step that writes the chosen
// slot. Input ready returns in the cycle after the result is loaded. A result
// held back by the output channel stalls the block until the output register
// can take it. The next word is accepted once the previous result has been
// moved to the output register, even if it has not yet been taken.
module assoc_tag_table_fifo_replace
    import atfr_pkg::*;
#(
    parameter int ENTRIES  = ENTRIES_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF,
    parameter int LEN_BITS = LEN_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              cmd,
    input  logic [KEY_W-1:0]  key,
    input  logic [LEN_W-1:0]  length,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              hit,
    output logic [SLOT_W-1:0] slot,
    output logic              evicted,
    output logic [LEN_W-1:0]  stored_length
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int DAT_W = KEY_BITS + LEN_BITS;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

    // Control state
    logic [1:0]         state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic               out_valid_reg, out_valid_next;

    // Working payload
    logic                cmd_reg, cmd_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [LEN_BITS-1:0] len_reg, len_next;
    logic                free_reg, free_next;
    logic                have_reg, have_next;
    logic [AGE_BITS-1:0] best_age_reg, best_age_next;
    logic [IDX_W-1:0]    victim_reg, victim_next;
    logic                res_hit_reg, res_hit_next;
    logic [IDX_W-1:0]    res_slot_reg, res_slot_next;
    logic                res_evict_reg, res_evict_next;
    logic [LEN_BITS-1:0] res_len_reg, res_len_next;

    // Output register
    logic                hit_reg, hit_next;
    logic [IDX_W-1:0]    slot_reg, slot_next;
    logic                evict_reg, evict_next;
    logic [LEN_BITS-1:0] olen_reg, olen_next;

    // RAM ports
    logic                dat_we;
    logic [DAT_W-1:0]    dat_rdata;
    logic                age_we;
    logic [IDX_W-1:0]    age_waddr;
    logic [AGE_BITS-1:0] age_wdata;
    logic [AGE_BITS-1:0] age_rdata;
    logic [IDX_W-1:0]    rd_addr;

    logic                accept;
    logic                out_load;
    logic                cur_valid;
    logic                is_last;
    logic [KEY_BITS-1:0] rd_key;
    logic [LEN_BITS-1:0] rd_len;
    logic [31:0]         len_in_wide;

    // Key and length store
    atfr_ram #(
        .WIDTH (DAT_W),
        .DEPTH (ENTRIES)
    ) u_dat_ram (
        .clk   (clk),
        .we    (dat_we),
        .waddr (victim_reg),
        .wdata ({key_reg, len_reg}),
        .raddr (rd_addr),
        .rdata (dat_rdata)
    );

    // Age store
    atfr_ram #(
        .WIDTH (AGE_BITS),
        .DEPTH (ENTRIES)
    ) u_age_ram (
        .clk   (clk),
        .we    (age_we),
        .waddr (age_waddr),
        .wdata (age_wdata),
        .raddr (rd_addr),
        .rdata (age_rdata)
    );

    assign in_ready    = (state_reg == ST_IDLE);
    assign accept      = in_valid && in_ready;
    assign rd_addr     = (state_reg == ST_SCAN) ? idx_reg + 1'b1 : '0;
    assign rd_key      = dat_rdata[DAT_W-1:LEN_BITS];
    assign rd_len      = dat_rdata[LEN_BITS-1:0];
    assign cur_valid   = valid_reg[idx_reg];
    assign is_last     = (idx_reg == IDX_LAST);
    assign len_in_wide = 32'(length);

    // Sequence the scan, commit and hand-over
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        valid_next     = valid_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        len_next       = len_reg;
        free_next      = free_reg;
        have_next      = have_reg;
        best_age_next  = best_age_reg;
        victim_next    = victim_reg;
        res_hit_next   = res_hit_reg;
        res_slot_next  = res_slot_reg;
        res_evict_next = res_evict_reg;
        res_len_next   = res_len_reg;
        dat_we         = 1'b0;
        age_we         = 1'b0;
        age_waddr      = idx_reg;
        age_wdata      = age_step(age_rdata);
        out_load       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next       = cmd;
                    key_next       = key[KEY_BITS-1:0];
                    len_next       = len_in_wide[LEN_BITS-1:0];
                    idx_next       = '0;
                    free_next      = 1'b0;
                    have_next      = 1'b0;
                    res_hit_next   = 1'b0;
                    res_slot_next  = '0;
                    res_evict_next = 1'b0;
                    res_len_next   = '0;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cmd_reg == CMD_LOOKUP)
                begin
                    // Stop at the lowest valid match
                    if (cur_valid && (rd_key == key_reg))
                    begin
                        res_hit_next  = 1'b1;
                        res_slot_next = idx_reg;
                        res_len_next  = rd_len;
                        state_next    = ST_DONE;
                    end
                    else if (is_last)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    // Age every valid slot; the victim is rewritten at commit
                    age_we = cur_valid;
                    if (!free_reg && !cur_valid)
                    begin
                        free_next   = 1'b1;
                        victim_next = idx_reg;
                    end
                    else if (!free_reg && cur_valid &&
                             (!have_reg || (age_rdata > best_age_reg)))
                    begin
                        have_next     = 1'b1;
                        best_age_next = age_rdata;
                        victim_next   = idx_reg;
                    end
                    if (is_last)
                    begin
                        state_next = ST_COMMIT;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_COMMIT:
            begin
                dat_we                 = 1'b1;
                age_we                 = 1'b1;
                age_waddr              = victim_reg;
                age_wdata              = '0;
                valid_next[victim_reg] = 1'b1;
                res_slot_next          = victim_reg;
                res_evict_next         = !free_reg;
                state_next             = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: load a finished result, drop on take
    always_comb
    begin
        out_valid_next = out_valid_reg;
        hit_next       = hit_reg;
        slot_next      = slot_reg;
        evict_next     = evict_reg;
        olen_next      = olen_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            hit_next       = res_hit_reg;
            slot_next      = res_slot_reg;
            evict_next     = res_evict_reg;
            olen_next      = res_len_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        key_reg       <= key_next;
        len_reg       <= len_next;
        free_reg      <= free_next;
        have_reg      <= have_next;
        best_age_reg  <= best_age_next;
        victim_reg    <= victim_next;
        res_hit_reg   <= res_hit_next;
        res_slot_reg  <= res_slot_next;
        res_evict_reg <= res_evict_next;
        res_len_reg   <= res_len_next;
        hit_reg       <= hit_next;
        slot_reg      <= slot_next;
        evict_reg     <= evict_next;
        olen_reg      <= olen_next;
    end

    logic [31:0] slot_wide;
    logic [31:0] olen_wide;

    assign slot_wide     = 32'(slot_reg);
    assign olen_wide     = 32'(olen_reg);
    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign slot          = slot_wide[SLOT_W-1:0];
    assign evicted       = evict_reg;
    assign stored_length = olen_wide[LEN_W-1:0];

    // Key and length are only written at commit
    assert property (@(posedge clk) disable iff (!rst_n)
        dat_we |-> (state_reg == ST_COMMIT))
        else $error("data RAM written outside commit");

    // Valid marks never clear once set
    assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_reg & $past(valid_reg)) == $past(valid_reg)))
        else $error("valid mark cleared");

    // A commit leaves its victim valid
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMMIT) |=> valid_reg[$past(victim_reg)])
        else $error("committed slot not valid");

    // A result is never loaded over an untaken one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten");

endmodule

/* src/atfr_ram.sv */
// ----------------------------------------------------------------------------
// atfr_ram
// Generic simple dual-port RAM: one write port, one read port and
// registered read data.
// ----------------------------------------------------------------------------
module atfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, register the read word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* test/assoc_tag_table_fifo_replace_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// assoc_tag_table_fifo_replace_tb
// Self-checking bench for the associative tag table with FIFO replacement.
// A behavioural copy of the table predicts hit, slot, eviction and stored
// length for every accepted word. Directed tests cover the empty table, a
// fill with extreme keys and lengths, duplicate keys and FIFO eviction. Random
// traffic then runs over a small key pool, with gaps on both channels.
// ----------------------------------------------------------------------------
module assoc_tag_table_fifo_replace_tb;
    import atfr_pkg::*;

    localparam int TABLE_SLOTS = ENTRIES_DEF;
    localparam int KEY_POOL    = 20;
    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 13;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              evicted;
        logic [LEN_W-1:0]  stored_length;
    } table_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              cmd = CMD_LOOKUP;
    logic [KEY_W-1:0]  key = '0;
    logic [LEN_W-1:0]  length = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    logic [LEN_W-1:0]  stored_length;

    // Shadow copy of the table
    logic                tbl_valid [TABLE_SLOTS];
    logic [KEY_W-1:0]    tbl_key   [TABLE_SLOTS];
    logic [AGE_BITS-1:0] tbl_age   [TABLE_SLOTS];
    logic [LEN_W-1:0]    tbl_len   [TABLE_SLOTS];

    table_result_t pending_results[$];
    logic [KEY_W-1:0] key_pool [KEY_POOL];
    int  error_count = 0;
    int  cycle_count = 0;
    bit  no_idle = 1'b0;

    assoc_tag_table_fifo_replace DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .key          (key),
        .length       (length),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hit          (hit),
        .slot         (slot),
        .evicted      (evicted),
        .stored_length(stored_length)
    );

    always #5 clk = ~clk;

    // Apply one word to the shadow table and return the result it yields
    function automatic table_result_t table_apply(input logic c, input logic [KEY_W-1:0] k,
                                                  input logic [LEN_W-1:0] l);
        table_result_t r;
        int victim;
        bit found;
        r = '0;
        found = 1'b0;
        victim = -1;
        if (c == CMD_LOOKUP)
        begin
            // Lowest valid matching slot wins
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                if (!found && tbl_valid[i] && tbl_key[i] == k)
                begin
                    found = 1'b1;
                    r.hit = 1'b1;
                    r.slot = i[SLOT_W-1:0];
                    r.stored_length = tbl_len[i];
                end
            end
        end
        else
        begin
            // Lowest free slot, else the strictly oldest one
            for (int i = 0; i < TABLE_SLOTS; i++)
                if (victim < 0 && !tbl_valid[i])
                    victim = i;
            if (victim < 0)
            begin
                r.evicted = 1'b1;
                victim = 0;
                for (int i = 1; i < TABLE_SLOTS; i++)
                    if (tbl_age[i] > tbl_age[victim])
                        victim = i;
            end
            tbl_valid[victim] = 1'b1;
            tbl_key[victim]   = k;
            tbl_len[victim]   = l;
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                if (i == victim)
                    tbl_age[i] = '0;
                else if (tbl_age[i] != AGE_MAX)
                    tbl_age[i] = tbl_age[i] + 1'b1;
            end
            r.slot = victim[SLOT_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] rand_key();
        return {$urandom(), $urandom()};
    endfunction

    // Present one word, hold it until taken, then queue its prediction
    task automatic send_word(input logic c, input logic [KEY_W-1:0] k,
                             input logic [LEN_W-1:0] l);
        if (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        key      <= k;
        length   <= l;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        pending_results.push_back(table_apply(c, k, l));
    endtask

    // Mostly pool keys, so lookups hit and inserts duplicate; some fresh ones
    task automatic send_random_word();
        logic c;
        logic [KEY_W-1:0] k;
        int pick;
        c = ($urandom_range(99) < 45) ? CMD_INSERT : CMD_LOOKUP;
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            k = key_pool[$urandom_range(KEY_POOL - 1)];
        end
        else if (pick < 96)
        begin
            k = rand_key();
            if (c == CMD_INSERT)
                key_pool[$urandom_range(KEY_POOL - 1)] = k;
        end
        else
        begin
            k = $urandom_range(1) ? '1 : '0;
        end
        send_word(c, k, LEN_W'($urandom_range(0, (1 << LEN_W) - 1)));
    endtask

    // Drop valid and hold off until every result has come back
    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_lookup();
        send_word(CMD_LOOKUP, '0, '1);
        send_word(CMD_LOOKUP, '1, '0);
    endtask

    // Fill every slot with extreme keys and lengths, then look two up
    task automatic test_fill_extremes();
        logic [KEY_W-1:0] k;
        logic [LEN_W-1:0] l;
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            case (i)
                0:       k = '0;
                1:       k = '1;
                2:       k = {KEY_W/2{2'b01}};
                3:       k = {KEY_W/2{2'b10}};
                default: k = 64'h1 << (i * 4 - 1);
            endcase
            case (i % 4)
                0:       l = '0;
                1:       l = '1;
                2:       l = {LEN_W/2{2'b10}};
                default: l = {LEN_W/2{2'b01}};
            endcase
            send_word(CMD_INSERT, k, l);
        end
        send_word(CMD_LOOKUP, '0, '0);
        send_word(CMD_LOOKUP, '1, '0);
    endtask

    // Duplicate insert into a full table evicts the oldest; lowest match wins
    task automatic test_duplicate_evict();
        send_word(CMD_INSERT, '1, 20'h12345);
        send_word(CMD_LOOKUP, '1, '0);
        send_word(CMD_LOOKUP, '0, '0);
        send_word(CMD_INSERT, {KEY_W/4{4'hC}}, 20'hABCDE);
        send_word(CMD_LOOKUP, '1, '1);
    endtask

    task automatic test_random_traffic(input int count);
        for (int i = 0; i < KEY_POOL; i++)
            key_pool[i] = rand_key();
        repeat (count) send_random_word();
    endtask

    // Long stretch with no idling on either channel
    task automatic test_steady_stream(input int count);
        no_idle = 1'b1;
        repeat (count) send_random_word();
        no_idle = 1'b0;
    endtask

    // Bursts with a full drain between them
    task automatic test_drain_bursts(input int bursts, input int per_burst);
        repeat (bursts)
        begin
            repeat (per_burst) send_random_word();
            wait_all_results();
        end
    endtask

    // Randomly stall the result channel
    always @(posedge clk)
        out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);

    task automatic report_field(input string name, input logic [LEN_W-1:0] exp_v,
                                input logic [LEN_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    // Compare each result word with the oldest prediction
    always @(posedge clk)
    begin
        table_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual hit=%0b slot=%0d",
                         $time, hit, slot);
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                report_field("hit", LEN_W'(exp_r.hit), LEN_W'(hit));
                report_field("slot", LEN_W'(exp_r.slot), LEN_W'(slot));
                report_field("evicted", LEN_W'(exp_r.evicted), LEN_W'(evicted));
                report_field("stored_length", exp_r.stored_length, stored_length);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_key[i]   = '0;
            tbl_age[i]   = '0;
            tbl_len[i]   = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_lookup();
        test_fill_extremes();
        test_duplicate_evict();
        test_random_traffic(160);
        test_steady_stream(80);
        test_drain_bursts(5, 32);

        wait_all_results();
        repeat (30) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* sim.f */
src/atfr_pkg.sv
src/atfr_ram.sv
src/assoc_tag_table_fifo_replace.sv
test/assoc_tag_table_fifo_replace_tb.sv
